// ===== rtl/core/mrp_pkg.sv =====
// ----------------------------------------------------------------------------
// mrp_pkg: shared types and constants of the interrupt-controller table parser
// Holds the record type codes, the list sizes, the request and result
// structures and a little-endian word helper.
// ----------------------------------------------------------------------------
`default_nettype none

package mrp_pkg;

  // list capacities
  localparam int MaxCpus    = 16;
  localparam int MaxIoCtrls = 8;

  // count widths, fixed by the result fields
  localparam int CpuCntW = 5;
  localparam int IoCntW  = 4;

  // record type codes
  localparam logic [7:0] MadtCpu    = 8'd0;
  localparam logic [7:0] MadtIoapic = 8'd1;
  localparam logic [7:0] MadtInt    = 8'd2;

  // minimum record lengths per type
  localparam logic [7:0] CpuMinLen      = 8'd8;
  localparam logic [7:0] IoapicMinLen   = 8'd12;
  localparam logic [7:0] OverrideMinLen = 8'd10;

  // field buffer: header bytes 0..7, record bytes 2..11
  localparam int FieldDepth = 10;
  localparam int FieldIdxW  = $clog2(FieldDepth);
  localparam int HeaderLen  = 8;
  localparam int HeaderIdxW = $clog2(HeaderLen);

  // output stream data width (fields padded to whole bytes)
  localparam int OutDataW = 104;

  typedef enum logic [1:0] {
    OP_HEADER,
    OP_RECORD,
    OP_END
  } op_e;

  typedef enum logic [2:0] {
    KIND_HEADER   = 3'd0,
    KIND_CPU      = 3'd1,
    KIND_IO       = 3'd2,
    KIND_OVERRIDE = 3'd3,
    KIND_IGNORED  = 3'd4,
    KIND_END      = 3'd5
  } kind_e;

  typedef logic [FieldDepth-1:0][7:0] fields_t;

  // request from the front part to the back part
  typedef struct packed {
    op_e        op;
    logic [7:0] rec_kind;
    logic [7:0] rec_len;
    fields_t    fields;
    logic       last;
  } task_t;

  // one result item
  typedef struct packed {
    kind_e              kind;
    logic [7:0]         slot;
    logic [7:0]         ident;
    logic [7:0]         apic_ident;
    logic [31:0]        address;
    logic [31:0]        base;
    logic [CpuCntW-1:0] cpus_found;
    logic [IoCntW-1:0]  ios_found;
    logic               table_full;
    logic               end_of_table;
  } result_t;

  // little-endian 32-bit word starting at a fixed buffer position
  function automatic logic [31:0] word_at(fields_t f, int unsigned pos);
    return {f[pos+3], f[pos+2], f[pos+1], f[pos]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mrp_front.sv =====
// ----------------------------------------------------------------------------
// mrp_front: byte walker of the table parser
// Accepts one byte per cycle while ready, tracks header and record position,
// fills the field buffer and issues a request per completed header or record.
// ----------------------------------------------------------------------------
`default_nettype none

module mrp_front import mrp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  input  wire logic       ready_i,
  input  wire logic [7:0] data_i,
  input  wire logic       last_i,
  output task_t           task_o,
  output logic            push_o
);

  logic       in_header_q, in_header_d;
  logic       stopped_q, stopped_d;
  logic [7:0] offset_q, offset_d;
  logic [7:0] rec_kind_q, rec_kind_d;
  logic [7:0] rec_len_q, rec_len_d;
  fields_t    fields_q, fields_d;
  logic       accept;
  logic [7:0] rec_idx;
  logic [8:0] next_off;

  assign accept   = valid_i && ready_i;
  assign rec_idx  = offset_q - 8'd2;
  assign next_off = {1'b0, offset_q} + 9'd1;

  // position tracking and request generation
  always_comb begin
    in_header_d = in_header_q;
    stopped_d   = stopped_q;
    offset_d    = offset_q;
    rec_kind_d  = rec_kind_q;
    rec_len_d   = rec_len_q;
    fields_d    = fields_q;
    push_o      = 1'b0;
    task_o.op   = OP_RECORD;
    if (accept) begin
      if (stopped_q) begin
        // bytes dropped until the last byte
      end else if (in_header_q) begin
        fields_d[offset_q[HeaderIdxW-1:0]] = data_i;
        if (offset_q == 8'(HeaderLen - 1)) begin
          push_o      = 1'b1;
          task_o.op   = OP_HEADER;
          in_header_d = 1'b0;
          offset_d    = 8'd0;
        end else begin
          offset_d = offset_q + 8'd1;
        end
      end else if (offset_q == 8'd0) begin
        rec_kind_d = data_i;
        offset_d   = 8'd1;
      end else begin
        if (offset_q == 8'd1) begin
          rec_len_d = data_i;
          if (data_i == 8'd0) begin
            stopped_d = 1'b1;
          end
        end else if (rec_idx < 8'(FieldDepth)) begin
          fields_d[rec_idx[FieldIdxW-1:0]] = data_i;
        end
        if (!stopped_d) begin
          if (next_off >= {1'b0, rec_len_d}) begin
            push_o    = 1'b1;
            task_o.op = OP_RECORD;
            offset_d  = 8'd0;
          end else begin
            offset_d = next_off[7:0];
          end
        end
      end
      // last byte closes the table
      if (last_i) begin
        if (!push_o) begin
          push_o    = 1'b1;
          task_o.op = OP_END;
        end
        in_header_d = 1'b1;
        offset_d    = 8'd0;
        stopped_d   = 1'b0;
      end
    end
    task_o.rec_kind = rec_kind_d;
    task_o.rec_len  = rec_len_d;
    task_o.fields   = fields_d;
    task_o.last     = last_i;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_header_q <= 1'b1;
      stopped_q   <= 1'b0;
      offset_q    <= 8'd0;
      rec_kind_q  <= 8'd0;
      rec_len_q   <= 8'd0;
    end else begin
      in_header_q <= in_header_d;
      stopped_q   <= stopped_d;
      offset_q    <= offset_d;
      rec_kind_q  <= rec_kind_d;
      rec_len_q   <= rec_len_d;
    end
  end

  // field buffer, no reset
  always_ff @(posedge clk_i) begin
    fields_q <= fields_d;
  end

  a_stop_not_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |-> !in_header_q)
    else $error("parser stopped while expecting a header");

  a_header_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_header_q |-> (offset_q < 8'(HeaderLen)))
    else $error("header offset out of range");

endmodule

`default_nettype wire

// ===== rtl/core/mrp_queue.sv =====
// ----------------------------------------------------------------------------
// mrp_queue: two-entry request queue
// Decouples the byte walker from the result stage so that each side can
// stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module mrp_queue import mrp_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire task_t task_i,
  output logic       ready_o,
  input  wire logic  pop_i,
  output logic       valid_o,
  output task_t      task_o
);

  task_t      entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push;
  logic       do_pop;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign task_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= task_i;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'd2)
    else $error("queue fill level out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> ready_o)
    else $error("request pushed into a full queue");

endmodule

`default_nettype wire

// ===== rtl/core/mrp_back.sv =====
// ----------------------------------------------------------------------------
// mrp_back: result stage of the table parser
// Classifies each completed header, record or table end, keeps the cpu and io
// list counts and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mrp_back import mrp_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  valid_i,
  input  wire task_t task_i,
  output logic       pop_o,
  output logic       valid_o,
  input  wire logic  ready_i,
  output result_t    result_o
);

  logic               out_valid_q;
  result_t            res_q, res_d;
  logic [CpuCntW-1:0] cpu_total_q, cpu_total_d;
  logic [IoCntW-1:0]  io_total_q, io_total_d;
  logic               cpu_enabled;

  assign pop_o       = valid_i && (!out_valid_q || ready_i);
  assign valid_o     = out_valid_q;
  assign result_o    = res_q;
  assign cpu_enabled = task_i.fields[2][0];

  // classify the request at the queue head
  always_comb begin
    cpu_total_d        = cpu_total_q;
    io_total_d         = io_total_q;
    res_d              = '0;
    res_d.kind         = KIND_IGNORED;
    res_d.end_of_table = task_i.last;
    case (task_i.op)
      OP_HEADER: begin
        res_d.kind    = KIND_HEADER;
        res_d.address = word_at(task_i.fields, 0);
        res_d.base    = word_at(task_i.fields, 4);
      end
      OP_RECORD: begin
        if (task_i.rec_kind == MadtCpu && task_i.rec_len >= CpuMinLen) begin
          if (!cpu_enabled) begin
            res_d.kind = KIND_IGNORED;
          end else if (cpu_total_q >= CpuCntW'(MaxCpus)) begin
            res_d.table_full = 1'b1;
          end else begin
            res_d.kind       = KIND_CPU;
            res_d.slot       = 8'(cpu_total_q);
            res_d.ident      = task_i.fields[0];
            res_d.apic_ident = task_i.fields[1];
            cpu_total_d      = cpu_total_q + CpuCntW'(1);
          end
        end else if (task_i.rec_kind == MadtIoapic && task_i.rec_len >= IoapicMinLen) begin
          if (io_total_q >= IoCntW'(MaxIoCtrls)) begin
            res_d.table_full = 1'b1;
          end else begin
            res_d.kind    = KIND_IO;
            res_d.slot    = 8'(io_total_q);
            res_d.ident   = task_i.fields[0];
            res_d.address = word_at(task_i.fields, 2);
            res_d.base    = word_at(task_i.fields, 6);
            io_total_d    = io_total_q + IoCntW'(1);
          end
        end else if (task_i.rec_kind == MadtInt && task_i.rec_len >= OverrideMinLen) begin
          res_d.kind = KIND_OVERRIDE;
          res_d.slot = task_i.fields[1];
          res_d.base = word_at(task_i.fields, 2);
        end
      end
      OP_END: begin
        res_d.kind = KIND_END;
      end
      default: begin
        res_d.kind = KIND_IGNORED;
      end
    endcase
    res_d.cpus_found = cpu_total_d;
    res_d.ios_found  = io_total_d;
  end

  // counts and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cpu_total_q <= '0;
      io_total_q  <= '0;
    end else begin
      if (pop_o) begin
        out_valid_q <= 1'b1;
        cpu_total_q <= cpu_total_d;
        io_total_q  <= io_total_d;
      end else if (ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

  a_cpu_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cpu_total_q <= CpuCntW'(MaxCpus))
    else $error("cpu count beyond list size");

  a_io_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    io_total_q <= IoCntW'(MaxIoCtrls))
    else $error("io count beyond list size");

endmodule

`default_nettype wire

// ===== rtl/core/madt_record_parser.sv =====
// ----------------------------------------------------------------------------
// madt_record_parser: interrupt-controller table body parser
// Walks the header and type/length records of the table body and reports
// headers, added cpus, added io controllers, overrides and ignored records.
// ----------------------------------------------------------------------------
// The block takes one table byte per cycle and gives at most one result per
// byte; a byte is accepted every cycle as long as the two-entry request queue
// between the byte walker and the result stage has room, so a result waiting
// on the output does not stall input until two more results are pending.
// A completed request is held in the queue, then its result in the output
// register. The cpu and io counts persist across tables and are cleared only
// by reset.
`default_nettype none

module madt_record_parser import mrp_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // input stream: tdata = data_byte[7:0]; tlast = last_byte
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  wire logic [7:0]          s_axis_tdata_i,
  input  wire logic                s_axis_tlast_i,
  // output stream: tdata = slot[7:0], ident[15:8], apic_ident[23:16],
  // address[55:24], base[87:56], cpus_found[92:88], ios_found[96:93],
  // table_full[97], zero padding[103:98]
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  output logic [OutDataW-1:0]      m_axis_tdata_o,
  // tuser = kind[2:0]
  output logic [2:0]               m_axis_tuser_o,
  // tlast = end_of_table
  output logic                     m_axis_tlast_o
);

  task_t   front_task;
  logic    front_push;
  logic    queue_ready;
  logic    queue_valid;
  task_t   queue_task;
  logic    back_pop;
  result_t result;

  assign s_axis_tready_o = queue_ready;

  mrp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_i (queue_ready),
    .data_i  (s_axis_tdata_i),
    .last_i  (s_axis_tlast_i),
    .task_o  (front_task),
    .push_o  (front_push)
  );

  mrp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .task_i  (front_task),
    .ready_o (queue_ready),
    .pop_i   (back_pop),
    .valid_o (queue_valid),
    .task_o  (queue_task)
  );

  mrp_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (queue_valid),
    .task_i   (queue_task),
    .pop_o    (back_pop),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .result_o (result)
  );

  // pack the result onto the output stream
  assign m_axis_tdata_o = {6'd0, result.table_full, result.ios_found, result.cpus_found,
                           result.base, result.address, result.apic_ident,
                           result.ident, result.slot};
  assign m_axis_tuser_o = result.kind;
  assign m_axis_tlast_o = result.end_of_table;

endmodule

`default_nettype wire
